// File: design/uld_pkg.sv
package uld_pkg;

  localparam int LINE_BYTES = 64;
  localparam int IDX_W      = $clog2(LINE_BYTES);
  localparam int CNT_W      = 6;
  localparam int POS_W      = 7;
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = $clog2(Q_DEPTH);
  localparam int QFILL_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_BEGIN,
    MODE_DECODE,
    MODE_END,
    MODE_DONE
  } mode_t;

  typedef enum logic [2:0] {
    PH_LITERAL,
    PH_PRE_NUM,
    PH_SIGN,
    PH_DIGITS,
    PH_GAP,
    PH_MATCHED
  } phase_t;

  typedef enum logic [1:0] {
    REQ_CHAR    = 2'd0,
    REQ_EMPTY   = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_LOAD,
    B_STAT
  } back_state_t;

  // one closed line: bytes to drain from the line store, then a status
  typedef struct packed {
    logic [CNT_W-1:0] count;
    status_t          status;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic drain_done;
  } back_stat_t;

  function automatic logic [7:0] begin_letter(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h62;  // b
      3'd1:    c = 8'h65;  // e
      3'd2:    c = 8'h67;  // g
      3'd3:    c = 8'h69;  // i
      3'd4:    c = 8'h6E;  // n
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] end_letter(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = 8'h65;  // e
      2'd1:    c = 8'h6E;  // n
      2'd2:    c = 8'h64;  // d
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h37;
  endfunction

endpackage

// File: design/uld_if.sv
interface uld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] ch;
  logic       line_last;

  modport source (output valid, output req_type, output ch, output line_last, input ready);
  modport sink   (input valid, input req_type, input ch, input line_last, output ready);
endinterface

interface uld_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output kind, output data_byte, output status, output last,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input status, input last,
                  output ready);
endinterface

// File: design/uld_queue.sv
module uld_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  uld_pkg::cmd_t   push_data,
  input  logic            pop,
  output uld_pkg::cmd_t   pop_data,
  output uld_pkg::q_stat_t qstat
);
  import uld_pkg::*;

  cmd_t               slot_r [Q_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QFILL_W-1:0] fill_r, fill_nxt;

  assign pop_data    = slot_r[rd_ptr_r];
  assign qstat.full  = (fill_r == QFILL_W'(Q_DEPTH));
  assign qstat.empty = (fill_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/uld_front.sv
module uld_front (
  input  logic                clk,
  input  logic                rst_n,
  uld_in_if.sink              in_chan,
  input  uld_pkg::q_stat_t    qstat,
  input  uld_pkg::back_stat_t bstat,
  output logic                push,
  output uld_pkg::cmd_t       cmd,
  output uld_pkg::wr_t        wr
);
  import uld_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             bad_r, bad_nxt;
  phase_t           phase_r, phase_nxt;
  logic             ok_r, ok_nxt;
  logic [5:0]       hold0_r, hold0_nxt;
  logic [5:0]       hold1_r, hold1_nxt;
  logic [5:0]       hold2_r, hold2_nxt;
  logic [CNT_W-1:0] stored_r, stored_nxt;
  logic             busy_r, busy_nxt;
  logic             in_ready;

  // hold off while the line store is being drained or the command queue is full
  assign in_ready      = !busy_r && !qstat.full;
  assign in_chan.ready = in_ready;

  always_comb begin
    logic [7:0]       c;
    logic [5:0]       s;
    logic [POS_W-1:0] q;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] r;
    logic             valid_c;
    logic             needed;
    logic             closing;
    logic             clear;

    c       = in_chan.ch;
    s       = 6'(c - 8'd32);
    q       = pos_r - 1'b1;
    base    = {1'b0, q[6:2], 1'b0} + {2'b00, q[6:2]};
    r       = POS_W'({1'b0, count_r}) - base;
    valid_c = (c >= 8'h21) && (c <= 8'h60);
    needed  = 1'b0;
    closing = 1'b0;
    clear   = 1'b0;

    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    bad_nxt    = bad_r;
    phase_nxt  = phase_r;
    ok_nxt     = ok_r;
    hold0_nxt  = hold0_r;
    hold1_nxt  = hold1_r;
    hold2_nxt  = hold2_r;
    stored_nxt = stored_r;
    busy_nxt   = busy_r && !bstat.drain_done;
    push       = 1'b0;
    cmd.count  = '0;
    cmd.status = ST_OK;
    wr.en      = 1'b0;
    wr.addr    = '0;
    wr.data    = '0;

    if (in_chan.valid && in_ready) begin
      case (req_t'(in_chan.req_type))
        REQ_RESTART: begin
          mode_nxt = MODE_BEGIN;
          clear    = 1'b1;
        end
        REQ_EMPTY: closing = 1'b1;
        REQ_CHAR: begin
          case (mode_r)
            MODE_BEGIN: begin
              if (ok_r && phase_r != PH_MATCHED) begin
                case (phase_r)
                  PH_LITERAL: begin
                    if (pos_r >= 7'd5 || c != begin_letter(pos_r[2:0])) begin
                      ok_nxt = 1'b0;
                    end else if (pos_r == 7'd4) begin
                      phase_nxt = PH_PRE_NUM;
                    end
                  end
                  PH_PRE_NUM: begin
                    if (!is_ws(c)) begin
                      if (c == 8'h2B || c == 8'h2D) begin
                        phase_nxt = PH_SIGN;
                      end else if (is_oct(c)) begin
                        phase_nxt = PH_DIGITS;
                      end else begin
                        ok_nxt = 1'b0;
                      end
                    end
                  end
                  PH_SIGN: begin
                    if (is_oct(c)) begin
                      phase_nxt = PH_DIGITS;
                    end else begin
                      ok_nxt = 1'b0;
                    end
                  end
                  PH_DIGITS: begin
                    if (!is_oct(c)) begin
                      phase_nxt = is_ws(c) ? PH_GAP : PH_MATCHED;
                    end
                  end
                  default: begin
                    if (!is_ws(c)) begin
                      phase_nxt = PH_MATCHED;
                    end
                  end
                endcase
              end
            end
            MODE_DECODE: begin
              if (pos_r == '0) begin
                if (is_ws(c)) begin
                  bad_nxt = 1'b1;
                end else begin
                  count_nxt = s;
                end
              end else if (!bad_r && count_r != '0 && base < POS_W'({1'b0, count_r})) begin
                case (q[1:0])
                  2'd2:    needed = (r > 7'd1);
                  2'd3:    needed = (r > 7'd2);
                  default: needed = 1'b1;
                endcase
                if (needed && !valid_c) begin
                  bad_nxt = 1'b1;
                end else begin
                  case (q[1:0])
                    2'd0: hold0_nxt = s;
                    2'd1: begin
                      wr.en      = 1'b1;
                      wr.addr    = IDX_W'(base);
                      wr.data    = {hold0_r, s[5:4]};
                      stored_nxt = CNT_W'(base + 7'd1);
                      hold1_nxt  = s;
                    end
                    2'd2: begin
                      if (r > 7'd1) begin
                        wr.en      = 1'b1;
                        wr.addr    = IDX_W'(base + 7'd1);
                        wr.data    = {hold1_r[3:0], s[5:2]};
                        stored_nxt = CNT_W'(base + 7'd2);
                      end
                      hold2_nxt = s;
                    end
                    default: begin
                      if (r > 7'd2) begin
                        wr.en      = 1'b1;
                        wr.addr    = IDX_W'(base + 7'd2);
                        wr.data    = {hold2_r[1:0], s};
                        stored_nxt = CNT_W'(base + 7'd3);
                      end
                    end
                  endcase
                end
              end
            end
            MODE_END: begin
              if (pos_r < 7'd3 && c != end_letter(pos_r[1:0])) begin
                ok_nxt = 1'b0;
              end
            end
            default: ;
          endcase
          if (pos_r != {POS_W{1'b1}}) begin
            pos_nxt = pos_r + 1'b1;
          end
          closing = in_chan.line_last;
        end
        default: ;
      endcase

      if (closing) begin
        case (mode_r)
          MODE_BEGIN: begin
            if (ok_nxt && phase_nxt == PH_MATCHED) begin
              mode_nxt = MODE_DECODE;
            end
          end
          MODE_DECODE: begin
            if (pos_nxt != '0 && !bad_nxt) begin
              if (count_nxt == '0) begin
                mode_nxt = MODE_END;
              end else if (stored_nxt == count_nxt) begin
                cmd.count = stored_nxt;
              end
            end
          end
          MODE_END: begin
            cmd.status = (ok_nxt && pos_nxt >= 7'd3) ? ST_DONE : ST_ERROR;
            mode_nxt   = MODE_DONE;
          end
          default: cmd.status = ST_DONE;
        endcase
        push  = 1'b1;
        clear = 1'b1;
        if (cmd.count != '0) begin
          busy_nxt = 1'b1;
        end
      end

      if (clear) begin
        pos_nxt    = '0;
        count_nxt  = '0;
        bad_nxt    = 1'b0;
        phase_nxt  = PH_LITERAL;
        ok_nxt     = 1'b1;
        hold0_nxt  = '0;
        hold1_nxt  = '0;
        hold2_nxt  = '0;
        stored_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BEGIN;
      pos_r    <= '0;
      count_r  <= '0;
      bad_r    <= 1'b0;
      phase_r  <= PH_LITERAL;
      ok_r     <= 1'b1;
      hold0_r  <= '0;
      hold1_r  <= '0;
      hold2_r  <= '0;
      stored_r <= '0;
      busy_r   <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      count_r  <= count_nxt;
      bad_r    <= bad_nxt;
      phase_r  <= phase_nxt;
      ok_r     <= ok_nxt;
      hold0_r  <= hold0_nxt;
      hold1_r  <= hold1_nxt;
      hold2_r  <= hold2_nxt;
      stored_r <= stored_nxt;
      busy_r   <= busy_nxt;
    end
  end

endmodule

// File: design/uld_back.sv
module uld_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  uld_pkg::wr_t         wr,
  input  uld_pkg::q_stat_t     qstat,
  input  uld_pkg::cmd_t        pop_data,
  output logic                 pop,
  output uld_pkg::back_stat_t  bstat,
  uld_out_if.source            out_chan
);
  import uld_pkg::*;

  logic [7:0]       line_mem [LINE_BYTES];
  logic [7:0]       rd_data_r;

  back_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  status_t          status_r, status_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r;
  logic [7:0]       out_data_r;
  status_t          out_status_r;
  logic             out_free;
  logic             load_data;
  logic             load_stat;

  assign out_free = !out_valid_r || out_chan.ready;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.kind      = out_kind_r;
  assign out_chan.data_byte = out_data_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.last      = (out_kind_r == KIND_STATUS);

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    status_nxt       = status_r;
    idx_nxt          = idx_r;
    pop              = 1'b0;
    load_data        = 1'b0;
    load_stat        = 1'b0;
    bstat.drain_done = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!qstat.empty) begin
          pop        = 1'b1;
          count_nxt  = pop_data.count;
          status_nxt = pop_data.status;
          idx_nxt    = '0;
          state_nxt  = (pop_data.count != '0) ? B_READ : B_STAT;
        end
      end
      B_READ: state_nxt = B_LOAD;
      B_LOAD: begin
        if (out_free) begin
          load_data = 1'b1;
          idx_nxt   = idx_r + 1'b1;
          if (CNT_W'(idx_r) == count_r - 1'b1) begin
            bstat.drain_done = 1'b1;
            state_nxt        = B_STAT;
          end else begin
            state_nxt = B_READ;
          end
        end
      end
      B_STAT: begin
        if (out_free) begin
          load_stat = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    if (load_data || load_stat) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      count_r     <= '0;
      status_r    <= ST_OK;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      line_mem[wr.addr] <= wr.data;
    end
    rd_data_r <= line_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (load_data) begin
      out_kind_r   <= KIND_DATA;
      out_data_r   <= rd_data_r;
      out_status_r <= ST_OK;
    end else if (load_stat) begin
      out_kind_r   <= KIND_STATUS;
      out_data_r   <= '0;
      out_status_r <= status_r;
    end
  end

endmodule

// File: design/uudecode_line_engine.sv
// Channel   | Dir | Fields                          | Transfer
// ----------+-----+---------------------------------+-------------------
// in_chan   | in  | req_type[1:0] ch[7:0] line_last | valid && ready
// out_chan  | out | kind data_byte[7:0] status[1:0] | valid && ready
//                   last
//
// Character items are accepted back to back. A closing item queues a line
// command; its run of n bytes then drains one by one (memory read, then
// output register), followed by the status.
// Input stalls while a line with bytes is still draining from the line
// store, or when the two-entry command queue is full.
// Reset is synchronous, active low; the line store needs no clearing.
module uudecode_line_engine (
  input  logic      clk,
  input  logic      rst_n,
  uld_in_if.sink    in_chan,
  uld_out_if.source out_chan
);
  import uld_pkg::*;

  logic       push;
  logic       pop;
  cmd_t       push_cmd;
  cmd_t       pop_cmd;
  wr_t        wr;
  q_stat_t    qstat;
  back_stat_t bstat;

  uld_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .qstat   (qstat),
    .bstat   (bstat),
    .push    (push),
    .cmd     (push_cmd),
    .wr      (wr)
  );

  uld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .qstat     (qstat)
  );

  uld_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .qstat    (qstat),
    .pop_data (pop_cmd),
    .pop      (pop),
    .bstat    (bstat),
    .out_chan (out_chan)
  );

endmodule

// File: tb/uudecode_line_engine_test.sv
`timescale 1ns / 100ps

module uudecode_line_engine_test;
  import uld_pkg::*;

  typedef logic [7:0] text_t[$];

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    status_t    status;
    logic       last;
  } result_t;

  localparam int STALL_LIMIT = 2000;
  localparam logic [39:0] HEAD_WORD = "begin";
  localparam logic [23:0] TAIL_WORD = "end";

  logic clk;
  logic rst_n;

  uld_in_if  in_chan ();
  uld_out_if out_chan ();

  uudecode_line_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predictor state
  mode_t      lmode;
  logic [6:0] col;
  logic [5:0] want_n;
  logic       skip_line;
  phase_t     hdr_phase;
  logic       pat_ok;
  logic [5:0] six [3];
  logic [7:0] byte_buf [64];
  logic [5:0] got_n;

  result_t expected_decode[$];
  result_t oldest;
  int      fails;
  int      items_sent;
  int      stall_count;
  bit      steady;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic is_blank_char(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_octal_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h37;
  endfunction

  function automatic void clear_line_state();
    col       = '0;
    want_n    = '0;
    skip_line = 1'b0;
    hdr_phase = PH_LITERAL;
    pat_ok    = 1'b1;
    six       = '{default: '0};
    got_n     = '0;
  endfunction

  function automatic void put_decoded(int idx, logic [7:0] b);
    byte_buf[idx] = b;
    got_n         = 6'(idx + 1);
  endfunction

  function automatic void close_line_predict();
    status_t st;
    st = ST_OK;
    case (lmode)
      MODE_BEGIN: begin
        if (pat_ok && hdr_phase == PH_MATCHED) lmode = MODE_DECODE;
      end
      MODE_DECODE: begin
        if (col != 0 && !skip_line) begin
          if (want_n == 0) lmode = MODE_END;
          else if (got_n == want_n)
            for (int i = 0; i < got_n; i++)
              expected_decode.push_back(result_t'{KIND_DATA, byte_buf[i], ST_OK, 1'b0});
        end
      end
      MODE_END: begin
        st    = (pat_ok && col >= 3) ? ST_DONE : ST_ERROR;
        lmode = MODE_DONE;
      end
      default: st = ST_DONE;
    endcase
    expected_decode.push_back(result_t'{KIND_STATUS, 8'h00, st, 1'b1});
    clear_line_state();
  endfunction

  function automatic void predict_decode(req_t rq, logic [7:0] c, logic lst);
    int         q, k, base, r;
    logic [5:0] s;
    logic       need;
    if (rq == REQ_RESTART) begin
      lmode = MODE_BEGIN;
      clear_line_state();
    end else if (rq == REQ_EMPTY) begin
      close_line_predict();
    end else if (rq == REQ_CHAR) begin
      case (lmode)
        MODE_BEGIN: begin
          if (pat_ok && hdr_phase != PH_MATCHED) begin
            case (hdr_phase)
              PH_LITERAL: begin
                if (col >= 5 || c != HEAD_WORD[8*(4-col) +: 8]) pat_ok = 1'b0;
                else if (col == 4) hdr_phase = PH_PRE_NUM;
              end
              PH_PRE_NUM: begin
                if (!is_blank_char(c)) begin
                  if (c == "+" || c == "-") hdr_phase = PH_SIGN;
                  else if (is_octal_digit(c)) hdr_phase = PH_DIGITS;
                  else pat_ok = 1'b0;
                end
              end
              PH_SIGN: begin
                if (is_octal_digit(c)) hdr_phase = PH_DIGITS;
                else pat_ok = 1'b0;
              end
              PH_DIGITS: begin
                if (!is_octal_digit(c)) hdr_phase = is_blank_char(c) ? PH_GAP : PH_MATCHED;
              end
              default: begin
                if (!is_blank_char(c)) hdr_phase = PH_MATCHED;
              end
            endcase
          end
        end
        MODE_DECODE: begin
          if (col == 0) begin
            if (is_blank_char(c)) skip_line = 1'b1;
            else want_n = 6'(c - 8'd32);
          end else if (!skip_line && want_n != 0) begin
            q    = int'(col) - 1;
            k    = q % 4;
            base = (q / 4) * 3;
            if (base < want_n) begin
              r    = want_n - base;
              need = k < 2 || (k == 2 && r > 1) || (k == 3 && r > 2);
              if (need && !(c >= 8'h21 && c <= 8'h60)) begin
                skip_line = 1'b1;
              end else begin
                s = 6'(c - 8'd32);
                case (k)
                  0: six[0] = s;
                  1: begin
                    put_decoded(base, {six[0], s[5:4]});
                    six[1] = s;
                  end
                  2: begin
                    if (r > 1) put_decoded(base + 1, {six[1][3:0], s[5:2]});
                    six[2] = s;
                  end
                  default: if (r > 2) put_decoded(base + 2, {six[2][1:0], s});
                endcase
              end
            end
          end
        end
        MODE_END: begin
          if (col < 3 && c != TAIL_WORD[8*(2-col) +: 8]) pat_ok = 1'b0;
        end
        default: ;
      endcase
      if (col < 127) col = col + 1'b1;
      if (lst) close_line_predict();
    end
  endfunction

  function automatic text_t as_text(string s);
    text_t t;
    foreach (s[i]) t.push_back(s[i]);
    return t;
  endfunction

  function automatic text_t noise(int len);
    text_t t;
    repeat (len) t.push_back(8'($urandom));
    return t;
  endfunction

  function automatic logic [7:0] ws_char();
    return $urandom_range(0, 5) == 0 ? 8'h20 : 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] sextet_char(logic [5:0] s);
    return s == 0 ? 8'h60 : 8'(32 + s);
  endfunction

  // count character, then groups of four; unneeded tail characters vary
  function automatic text_t uu_line(int n);
    text_t      t;
    logic [7:0] c;
    logic [7:0] b [3];
    logic [5:0] s [4];
    int         used;
    c = 8'(32 + n + 64 * $urandom_range(0, 3));
    if (is_blank_char(c)) c = 8'(96 + n);
    t.push_back(c);
    for (int base = 0; base < n; base += 3) begin
      foreach (b[j]) b[j] = 8'($urandom);
      s[0] = b[0][7:2];
      s[1] = {b[0][1:0], b[1][7:4]};
      s[2] = {b[1][3:0], b[2][7:6]};
      s[3] = b[2][5:0];
      used = (n - base >= 3) ? 4 : n - base + 1;
      for (int k = 0; k < 4; k++) begin
        if (k < used) t.push_back(sextet_char(s[k]));
        else if ($urandom_range(0, 2) == 0) break;
        else if ($urandom_range(0, 1) == 0) t.push_back(8'($urandom));
        else t.push_back(sextet_char(s[k]));
      end
    end
    if ($urandom_range(0, 3) == 0) t = {t, noise($urandom_range(1, 3))};
    return t;
  endfunction

  task automatic transfer_item(req_t rq, logic [7:0] c, logic lst);
    @(negedge clk);
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_chan.valid     = 1'b1;
    in_chan.req_type  = rq;
    in_chan.ch        = c;
    in_chan.line_last = lst;
    do @(posedge clk); while (!in_chan.ready);
    predict_decode(rq, c, lst);
    if (rq != REQ_NONE) items_sent++;
  endtask

  task automatic send_line(text_t t, bit via_empty);
    if (t.size() == 0) begin
      transfer_item(REQ_EMPTY, 8'($urandom), 1'($urandom));
    end else begin
      foreach (t[i]) transfer_item(REQ_CHAR, t[i], !via_empty && i == t.size() - 1);
      if (via_empty) transfer_item(REQ_EMPTY, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic drain_expected();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (expected_decode.size() != 0) @(negedge clk);
  endtask

  task automatic test_header_line();
    send_line(as_text("begin 7"), 1'b0);  // digits with nothing after: no match
    transfer_item(REQ_NONE, 8'hFF, 1'b1);
    send_line(as_text("begin+6 a"), 1'b0);
    drain_expected();
  endtask

  task automatic test_data_lines();
    text_t t;
    send_line(as_text(" ab"), 1'b0);
    send_line(as_text(""), 1'b0);
    send_line(uu_line(1), 1'b0);
    t    = uu_line(4);
    t[1] = 8'h00;
    send_line(t, 1'b0);
    t = uu_line(3);
    send_line(t[0:2], 1'b0);             // third and fourth characters of the group missing
    send_line(uu_line(2), 1'b1);
    drain_expected();
  endtask

  task automatic test_trailer();
    send_line(uu_line(0), 1'b0);
    send_line(as_text("en"), 1'b0);
    send_line(as_text("end"), 1'b0);
    transfer_item(REQ_RESTART, 8'h00, 1'b0);
    drain_expected();
  endtask

  task automatic random_session(bit widest);
    text_t t;
    int    n, sel, cut;
    bit    via_empty;
    if ($urandom_range(0, 3) != 0) transfer_item(REQ_RESTART, 8'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 1)) send_line(noise($urandom_range(0, 5)), 1'($urandom));
    t = as_text("begin");
    repeat ($urandom_range(0, 2)) t.push_back(ws_char());
    if ($urandom_range(0, 2) == 0) t.push_back($urandom_range(0, 1) ? "+" : "-");
    repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(8'h30, 8'h37)));
    repeat ($urandom_range(0, 2)) t.push_back(ws_char());
    if (widest || $urandom_range(0, 7) != 0)
      repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(33, 126)));
    if (!widest && $urandom_range(0, 5) == 0) t[$urandom_range(0, t.size() - 1)] = 8'($urandom);
    send_line(t, !widest && $urandom_range(0, 5) == 0);
    repeat (widest ? 1 : $urandom_range(1, 4)) begin
      if (widest) n = 63;
      else n = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 63) : $urandom_range(1, 9);
      t         = uu_line(n);
      sel       = widest ? 11 : $urandom_range(0, 11);
      via_empty = !widest && $urandom_range(0, 5) == 0;
      case (sel)
        0: t[1 + 4 * $urandom_range(0, (n - 1) / 3) + $urandom_range(0, 1)] =
             $urandom_range(0, 1) ? 8'($urandom_range(0, 32)) : 8'($urandom_range(97, 255));
        1: t = t[0:$urandom_range(0, t.size() - 2)];
        2: t[0] = ws_char();
        3: t.delete();
        4: begin
          // abandon the line part way
          cut = $urandom_range(1, t.size() - 1);
          for (int i = 0; i < cut; i++) transfer_item(REQ_CHAR, t[i], 1'b0);
          transfer_item(REQ_RESTART, 8'($urandom), 1'($urandom));
          return;
        end
        5: transfer_item(REQ_NONE, 8'($urandom), 1'($urandom));
        default: ;
      endcase
      send_line(t, via_empty);
    end
    if (!widest && $urandom_range(0, 7) == 0) return;
    send_line(uu_line(0), 1'b0);
    sel = $urandom_range(0, 5);
    case (sel)
      3: t = as_text("en");
      4: t.delete();
      5: begin
        t = as_text("end");
        t[$urandom_range(0, 2)] = 8'($urandom);
      end
      default: t = {as_text("end"), noise($urandom_range(0, 4))};
    endcase
    send_line(t, $urandom_range(0, 5) == 0);
    if ($urandom_range(0, 1) == 0) send_line(noise($urandom_range(0, 3)), 1'b0);
  endtask

  task automatic test_random();
    int start;
    bit paused;
    paused = 1'b0;
    start  = items_sent;
    while (items_sent < start + 40) begin
      if (!paused && items_sent >= start + 15) begin
        drain_expected();
        paused = 1'b1;
      end
      random_session(1'b0);
    end
    // close with the longest line and no idling
    steady = 1'b1;
    random_session(1'b1);
  endtask

  // result side back-pressure
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 5) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_chan.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_decode.size() == 0) begin
        $display("%0t: unexpected transfer: kind %0d byte %02h status %0d last %0d", $time,
                 out_chan.kind, out_chan.data_byte, out_chan.status, out_chan.last);
        fails++;
      end else begin
        oldest = expected_decode.pop_front();
        if (out_chan.kind !== oldest.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, oldest.kind, out_chan.kind);
          fails++;
        end
        if (out_chan.data_byte !== oldest.data_byte) begin
          $display("%0t: data_byte expected %02h actual %02h", $time, oldest.data_byte,
                   out_chan.data_byte);
          fails++;
        end
        if (out_chan.status !== oldest.status) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest.status,
                   out_chan.status);
          fails++;
        end
        if (out_chan.last !== oldest.last) begin
          $display("%0t: last expected %0d actual %0d", $time, oldest.last, out_chan.last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count == STALL_LIMIT) begin
        $display("uudecode_line_engine regression: fail");
        $finish;
      end
    end
  end

  initial begin
    in_chan.valid     = 1'b0;
    in_chan.req_type  = REQ_NONE;
    in_chan.ch        = 8'h00;
    in_chan.line_last = 1'b0;
    rst_n             = 1'b0;
    fails             = 0;
    items_sent        = 0;
    stall_count       = 0;
    steady            = 1'b0;
    lmode             = MODE_BEGIN;
    clear_line_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_header_line();
    test_data_lines();
    test_trailer();
    test_random();
    drain_expected();
    repeat (200) @(negedge clk);
    if (fails == 0) begin
      $display("uudecode_line_engine regression: pass");
    end else begin
      $display("uudecode_line_engine regression: fail");
    end
    $finish;
  end

endmodule
